// ===== rtl/qge_pkg.sv =====
// Shared types, codes and fixed-point helpers for the quadric grid evaluator.
// No dependencies; imported by quadric_grid_evaluator_core.
package qge_pkg;

  // Sizing
  localparam int unsigned MAX_RESOLUTION = 256;
  localparam int unsigned COEF_COUNT     = 10;

  // Pipeline stage indices, first register to output register
  localparam int unsigned ST_COORD   = 0;  // grid coordinates
  localparam int unsigned ST_PROD    = 1;  // 32x32 products
  localparam int unsigned ST_SUM     = 2;  // linear and matrix-row sums
  localparam int unsigned ST_PART    = 3;  // partial products of the quadratic term
  localparam int unsigned ST_MERGE   = 4;  // partials merged and saturated
  localparam int unsigned ST_QUAD    = 5;  // quadratic term
  localparam int unsigned ST_OUT     = 6;  // output register
  localparam int unsigned PIPE_DEPTH = 7;

  // Q32.16 and Q16.16 saturation bounds
  localparam logic signed [47:0] SAT48_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SAT48_MIN = {1'b1, {47{1'b0}}};
  localparam logic signed [31:0] SAT32_MAX = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] SAT32_MIN = {1'b1, {31{1'b0}}};

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    COEF_C   = 4'd0,
    COEF_LX  = 4'd1,
    COEF_LY  = 4'd2,
    COEF_LZ  = 4'd3,
    COEF_QXX = 4'd4,
    COEF_QYY = 4'd5,
    COEF_QZZ = 4'd6,
    COEF_QXY = 4'd7,
    COEF_QXZ = 4'd8,
    COEF_QYZ = 4'd9
  } coef_idx_e;

  typedef enum logic [3:0] {
    CFG_SPHERE_MODE = 4'd0,
    CFG_GRID_RES    = 4'd1,
    CFG_ORIGIN_X    = 4'd2,
    CFG_ORIGIN_Y    = 4'd3,
    CFG_ORIGIN_Z    = 4'd4,
    CFG_STEP_X      = 4'd5,
    CFG_STEP_Y      = 4'd6,
    CFG_STEP_Z      = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic               command;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic [7:0]         grid_i;
    logic [7:0]         grid_j;
    logic [7:0]         grid_k;
  } in_beat_t;

  typedef struct packed {
    logic signed [47:0] field_value;
    logic [23:0]        linear_index;
  } out_beat_t;

  // Coefficient slot exists in the bank
  function automatic logic coef_in_bank(input logic [3:0] idx);
    return 32'(idx) < COEF_COUNT;
  endfunction

  // Slots beyond the bank read as zero
  function automatic logic signed [31:0] coef_rd(input logic [3:0] idx,
                                                 input logic signed [31:0] val);
    return coef_in_bank(idx) ? val : '0;
  endfunction

  // origin + idx*step, exact, then clamped to Q16.16
  function automatic logic signed [31:0] grid_coord(input logic signed [31:0] origin,
                                                    input logic [30:0] step,
                                                    input logic [7:0] idx);
    logic [38:0]        prod;
    logic signed [40:0] sum;
    prod = idx * step;
    sum  = $signed({{9{origin[31]}}, origin}) + $signed({2'b00, prod});
    if (sum[40:31] != {10{sum[40]}}) return sum[40] ? SAT32_MIN : SAT32_MAX;
    return sum[31:0];
  endfunction

  // Saturating Q32.16 add
  function automatic logic signed [47:0] add48(input logic signed [47:0] a,
                                               input logic signed [47:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) return s[48] ? SAT48_MIN : SAT48_MAX;
    return s[47:0];
  endfunction

  // Clamp a 64-bit value to Q32.16
  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v[63:47] != {17{v[63]}}) return v[63] ? SAT48_MIN : SAT48_MAX;
    return v[47:0];
  endfunction

  // Q16.16 x Q16.16, floored to Q32.16; never leaves the 48-bit range
  function automatic logic signed [47:0] mul_q16(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:16];
  endfunction

endpackage

// ===== rtl/quadric_grid_evaluator_core.sv =====
// Quadric grid evaluator: pipelined c + l.x + x'Qx (sphere: qxx*r^2) on a 3D grid.
// Depends on qge_pkg (types, codes, fixed-point helpers).
//
// One beat enters per clock when the output side keeps up; an evaluate beat
// leaves through the output register, one result per evaluate and none per
// load. The datapath has seven registers: coordinates, the 32x32
// products, the row sums, the 48x32 quadratic multiply split over two stages,
// the quadratic sum and the output register. Load beats ride the first three
// stages and update the coefficient copy each stage reads as they pass, so a
// load is seen by every evaluate behind it and by none ahead of it. Bubbles
// collapse; stall on the output backs up stage by stage. Configuration is
// written through a port that is always ready and must only change while the
// pipeline is empty.
module quadric_grid_evaluator_core
  import qge_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // evaluate / load beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_beat_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_beat_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic               sphere_mode_q;
  logic [8:0]         grid_res_q;
  logic signed [31:0] origin_q [3];
  logic [30:0]        step_q   [3];
  logic [8:0]         res_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sphere_mode_q <= 1'b1;
      grid_res_q    <= 9'd64;
      for (int a = 0; a < 3; a++) begin
        origin_q[a] <= '0;
        step_q[a]   <= 31'd65536;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SPHERE_MODE: sphere_mode_q <= cfg_data_i[0];
        CFG_GRID_RES:    grid_res_q    <= cfg_data_i[8:0];
        CFG_ORIGIN_X:    origin_q[0]   <= cfg_data_i;
        CFG_ORIGIN_Y:    origin_q[1]   <= cfg_data_i;
        CFG_ORIGIN_Z:    origin_q[2]   <= cfg_data_i;
        CFG_STEP_X:      step_q[0]     <= cfg_data_i[30:0];
        CFG_STEP_Y:      step_q[1]     <= cfg_data_i[30:0];
        CFG_STEP_Z:      step_q[2]     <= cfg_data_i[30:0];
        default:         ;
      endcase
    end
  end

  // resolution limited to the supported maximum
  assign res_eff = (32'(grid_res_q) > MAX_RESOLUTION) ? 9'(MAX_RESOLUTION) : grid_res_q;

  // ------------------------------------------------------------------
  // Pipeline control: valid per stage, ready ripples back
  // ------------------------------------------------------------------
  logic [PIPE_DEPTH-1:0] valid_q, valid_d, ready, en;
  logic                  s1_eval_q, s2_eval_q, s3_eval_q;
  logic                  ld_prod, ld_sum, ld_part;

  always_comb begin
    ready[PIPE_DEPTH-1] = !valid_q[PIPE_DEPTH-1] || !out_stall_i;
    for (int s = PIPE_DEPTH - 2; s >= 0; s--) begin
      ready[s] = !valid_q[s] || ready[s+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    en      = '0;
    if (ready[0]) valid_d[0] = in_valid_i;
    en[0] = ready[0] && in_valid_i;
    for (int s = 1; s < PIPE_DEPTH; s++) begin
      if (ready[s]) begin
        // load beats end once the last coefficient copy has seen them
        if (s == ST_PART) valid_d[s] = valid_q[s-1] && s3_eval_q;
        else              valid_d[s] = valid_q[s-1];
      end
      en[s] = ready[s] && valid_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[ST_OUT];

  // a load beat leaving each stage updates the copy read by the next stage
  assign ld_prod = valid_q[ST_COORD] && !s1_eval_q && ready[ST_PROD];
  assign ld_sum  = valid_q[ST_PROD]  && !s2_eval_q && ready[ST_SUM];
  assign ld_part = valid_q[ST_SUM]   && !s3_eval_q && ready[ST_PART];

  // ------------------------------------------------------------------
  // Stage registers
  // ------------------------------------------------------------------
  // stage 1: coordinates, index partials
  logic [3:0]         s1_cidx_q;
  logic signed [31:0] s1_cval_q;
  logic signed [31:0] s1_crd_q [3];
  logic [7:0]         s1_i_q;
  logic [16:0]        s1_jres_q, s1_kres_q;
  // stage 2: products
  logic [3:0]         s2_cidx_q;
  logic signed [31:0] s2_cval_q;
  logic signed [31:0] s2_crd_q [3];
  logic [23:0]        s2_lin_q;
  logic signed [47:0] s2_lp_q [3];
  logic signed [47:0] s2_p_q  [3][3];
  // stage 3: sums
  logic [3:0]         s3_cidx_q;
  logic signed [31:0] s3_cval_q;
  logic signed [31:0] s3_crd_q [3];
  logic [23:0]        s3_lin_q;
  logic signed [47:0] s3_acc_q, s3_lz_q;
  logic signed [47:0] s3_u_q [3];
  // stage 4: quadratic partial products
  logic [23:0]        s4_lin_q;
  logic signed [47:0] s4_acc_q;
  logic signed [55:0] s4_ph_q [3];
  logic signed [56:0] s4_pl_q [3];
  // stage 5: merged products
  logic [23:0]        s5_lin_q;
  logic signed [47:0] s5_acc_q;
  logic signed [47:0] s5_m_q [3];
  // stage 6: quadratic term
  logic [23:0]        s6_lin_q;
  logic signed [47:0] s6_acc_q, s6_quad_q;
  // stage 7: output
  out_beat_t          out_q;

  // coefficient copies, one per consuming stage
  logic signed [31:0] lin_coef_q  [3];  // linear x, y, z
  logic signed [31:0] quad_coef_q [6];  // qxx, qyy, qzz, qxy, qxz, qyz
  logic signed [31:0] c0_q;
  logic signed [31:0] qxx_late_q;

  // ------------------------------------------------------------------
  // Stage logic
  // ------------------------------------------------------------------
  logic signed [31:0] s1_crd_d [3];
  logic [16:0]        s1_jres_d, s1_kres_d;
  logic [25:0]        kres2;
  logic [23:0]        s2_lin_d;
  logic signed [31:0] lc [3];
  logic signed [31:0] mat [3][3];
  logic signed [47:0] s2_lp_d [3];
  logic signed [47:0] s2_p_d  [3][3];
  logic signed [47:0] s3_acc_d, c0_ext;
  logic signed [47:0] s3_u_d [3];
  logic signed [47:0] s4_acc_d;
  logic signed [31:0] s4_b   [3];
  logic signed [55:0] s4_ph_d [3];
  logic signed [56:0] s4_pl_d [3];
  logic signed [79:0] full   [3];
  logic signed [47:0] s5_m_d [3];
  logic signed [47:0] s6_quad_d;

  // stage 1: grid coordinates and index partial products
  always_comb begin
    s1_crd_d[0] = grid_coord(origin_q[0], step_q[0], in_beat_i.grid_i);
    s1_crd_d[1] = grid_coord(origin_q[1], step_q[1], in_beat_i.grid_j);
    s1_crd_d[2] = grid_coord(origin_q[2], step_q[2], in_beat_i.grid_k);
    s1_jres_d   = in_beat_i.grid_j * res_eff;
    s1_kres_d   = in_beat_i.grid_k * res_eff;
  end

  // stage 2: linear index and all 32x32 products
  always_comb begin
    kres2    = s1_kres_q * res_eff;
    s2_lin_d = kres2[23:0] + {7'd0, s1_jres_q} + {16'd0, s1_i_q};
    lc[0] = coef_rd(COEF_LX, lin_coef_q[0]);
    lc[1] = coef_rd(COEF_LY, lin_coef_q[1]);
    lc[2] = coef_rd(COEF_LZ, lin_coef_q[2]);
    // row 0 doubles as the sum of squares in sphere mode
    mat[0][0] = sphere_mode_q ? s1_crd_q[0] : coef_rd(COEF_QXX, quad_coef_q[0]);
    mat[0][1] = sphere_mode_q ? s1_crd_q[1] : coef_rd(COEF_QXY, quad_coef_q[3]);
    mat[0][2] = sphere_mode_q ? s1_crd_q[2] : coef_rd(COEF_QXZ, quad_coef_q[4]);
    mat[1][0] = coef_rd(COEF_QXY, quad_coef_q[3]);
    mat[1][1] = coef_rd(COEF_QYY, quad_coef_q[1]);
    mat[1][2] = coef_rd(COEF_QYZ, quad_coef_q[5]);
    mat[2][0] = coef_rd(COEF_QXZ, quad_coef_q[4]);
    mat[2][1] = coef_rd(COEF_QYZ, quad_coef_q[5]);
    mat[2][2] = coef_rd(COEF_QZZ, quad_coef_q[2]);
    for (int t = 0; t < 3; t++) begin
      s2_lp_d[t] = mul_q16(s1_crd_q[t], lc[t]);
    end
    for (int r = 0; r < 3; r++) begin
      for (int t = 0; t < 3; t++) begin
        s2_p_d[r][t] = mul_q16(s1_crd_q[t], mat[r][t]);
      end
    end
  end

  // stage 3: constant plus first two linear terms, matrix rows (or r^2)
  always_comb begin
    c0_ext   = {{16{c0_q[31]}}, c0_q};
    c0_ext   = coef_in_bank(COEF_C) ? c0_ext : '0;
    s3_acc_d = add48(add48(c0_ext, s2_lp_q[0]), s2_lp_q[1]);
    for (int r = 0; r < 3; r++) begin
      s3_u_d[r] = add48(add48(s2_p_q[r][0], s2_p_q[r][1]), s2_p_q[r][2]);
    end
  end

  // stage 4: last linear term, 48x32 multiplies split into 24-bit halves
  always_comb begin
    s4_acc_d = add48(s3_acc_q, s3_lz_q);
    s4_b[0]  = sphere_mode_q ? coef_rd(COEF_QXX, qxx_late_q) : s3_crd_q[0];
    s4_b[1]  = s3_crd_q[1];
    s4_b[2]  = s3_crd_q[2];
    for (int r = 0; r < 3; r++) begin
      s4_ph_d[r] = $signed(s3_u_q[r][47:24]) * s4_b[r];
      s4_pl_d[r] = $signed({1'b0, s3_u_q[r][23:0]}) * s4_b[r];
    end
  end

  // stage 5: recombine halves, floor to Q32.16, saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      full[r]   = {s4_ph_q[r], 24'd0} + {{23{s4_pl_q[r][56]}}, s4_pl_q[r]};
      s5_m_d[r] = sat48(full[r][79:16]);
    end
  end

  // stage 6: quadratic term
  assign s6_quad_d = sphere_mode_q ? s5_m_q[0]
                                   : add48(add48(s5_m_q[0], s5_m_q[1]), s5_m_q[2]);

  // payload and coefficient registers
  always_ff @(posedge clk_i) begin
    if (en[ST_COORD]) begin
      s1_eval_q <= (in_beat_i.command == CMD_EVAL);
      s1_cidx_q <= in_beat_i.coef_index;
      s1_cval_q <= in_beat_i.coef_value;
      s1_crd_q  <= s1_crd_d;
      s1_i_q    <= in_beat_i.grid_i;
      s1_jres_q <= s1_jres_d;
      s1_kres_q <= s1_kres_d;
    end
    if (en[ST_PROD]) begin
      s2_eval_q <= s1_eval_q;
      s2_cidx_q <= s1_cidx_q;
      s2_cval_q <= s1_cval_q;
      s2_crd_q  <= s1_crd_q;
      s2_lin_q  <= s2_lin_d;
      s2_lp_q   <= s2_lp_d;
      s2_p_q    <= s2_p_d;
    end
    if (en[ST_SUM]) begin
      s3_eval_q <= s2_eval_q;
      s3_cidx_q <= s2_cidx_q;
      s3_cval_q <= s2_cval_q;
      s3_crd_q  <= s2_crd_q;
      s3_lin_q  <= s2_lin_q;
      s3_acc_q  <= s3_acc_d;
      s3_lz_q   <= s2_lp_q[2];
      s3_u_q    <= s3_u_d;
    end
    if (en[ST_PART]) begin
      s4_lin_q <= s3_lin_q;
      s4_acc_q <= s4_acc_d;
      s4_ph_q  <= s4_ph_d;
      s4_pl_q  <= s4_pl_d;
    end
    if (en[ST_MERGE]) begin
      s5_lin_q <= s4_lin_q;
      s5_acc_q <= s4_acc_q;
      s5_m_q   <= s5_m_d;
    end
    if (en[ST_QUAD]) begin
      s6_lin_q  <= s5_lin_q;
      s6_acc_q  <= s5_acc_q;
      s6_quad_q <= s6_quad_d;
    end
    if (en[ST_OUT]) begin
      out_q.field_value  <= add48(s6_acc_q, s6_quad_q);
      out_q.linear_index <= s6_lin_q;
    end

    // coefficient copies follow the load beats down the pipe
    if (ld_prod && coef_in_bank(s1_cidx_q)) begin
      if (s1_cidx_q >= COEF_LX && s1_cidx_q <= COEF_LZ) begin
        lin_coef_q[2'(s1_cidx_q - 4'(COEF_LX))] <= s1_cval_q;
      end
      if (s1_cidx_q >= COEF_QXX && s1_cidx_q <= COEF_QYZ) begin
        quad_coef_q[3'(s1_cidx_q - 4'(COEF_QXX))] <= s1_cval_q;
      end
    end
    if (ld_sum && coef_in_bank(s2_cidx_q) && s2_cidx_q == COEF_C) begin
      c0_q <= s2_cval_q;
    end
    if (ld_part && coef_in_bank(s3_cidx_q) && s3_cidx_q == COEF_QXX) begin
      qxx_late_q <= s3_cval_q;
    end
  end

  assign out_beat_o = out_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
`ifndef SYNTH
  // input backpressure only when every stage is occupied and the output stalls
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&valid_q) && out_stall_i))
    else $error("input stalled with a free pipeline slot");

  // a blocked first stage keeps its beat
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[ST_COORD] && !ready[ST_PROD]) |=>
      (valid_q[ST_COORD] && $stable(s1_crd_q[0]) && $stable(s1_eval_q)))
    else $error("first stage lost a blocked beat");

  // sum of squares is never negative
  a_r2_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[ST_SUM] && s3_eval_q && sphere_mode_q) |-> !s3_u_q[0][47])
    else $error("negative radius term in sphere mode");
`endif

endmodule
